FILE: rtl/pida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types, codes and field widths of the positional insert/delete list.
// ----------------------------------------------------------------------------
package pida_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W  = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 5;

	localparam int IN_W  = OP_W + POS_W + VAL_W;
	localparam int OUT_W = ST_W + VAL_W + CNT_W;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

	// Broadcast to every cell in the chain for one accepted item.
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} ctl_t;

endpackage

FILE: rtl/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered list of signed words with read, insert and delete at a position.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one item per request. tdata carries operation,
//    position and value. Accepted when s_tvalid and s_tready are high.
//  - Output channel m_*: one result item per request with status,
//    read_value and entry_count (count after the request).
//  - Latency: the result appears in the cycle after the request is taken.
//  - Throughput: one item per cycle unless the output stalls. The list
//    is a chain of CAPACITY cells, and those at or above the position
//    shift in the same cycle, so the chain, not an iteration, sets the rate.
//  - A read returns the entry before any change; out-of-range positions
//    report a bad position, an insert into a full list reports full, and
//    neither changes the list. Operation code 3 is a no-op with status done.
//  - Stall: the output register holds its item while m_tready is low;
//    s_tready stays high as long as the output register is empty or is
//    being emptied in the same cycle.
//  - Reset: arst_n clears the entry count and the output valid. Entry
//    words are not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
	parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [1:0] operation, [6:2] position, [38:7] value, [39] zero
	input  logic [pida_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] status, [33:2] read_value, [38:34] entry_count, [39] zero
	output logic [pida_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import pida_pkg::*;

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PCW = (CW > POS_W) ? CW : POS_W;

	// Unpack the request.
	logic [OP_W-1:0]         op;
	logic [POS_W-1:0]        pos;
	logic signed [VAL_W-1:0] value;

	assign op    = s_tdata[OP_W-1:0];
	assign pos   = s_tdata[OP_W +: POS_W];
	assign value = s_tdata[OP_W+POS_W +: VAL_W];

	logic                    accept;
	logic [CW-1:0]           count_q;
	logic [PCW-1:0]          pos_x;
	logic [PCW-1:0]          cnt_x;
	logic                    full;
	logic [ST_W-1:0]         status;
	logic                    do_ins;
	logic                    do_del;
	logic                    rd_ok;
	ctl_t                    ctl;
	logic signed [VAL_W-1:0] rd_bus;

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_x = PCW'(pos);
	assign cnt_x = PCW'(count_q);
	assign full  = (32'(count_q) == 32'(CAPACITY));

	// Decode status and what the chain does this cycle.
	always_comb begin
		status = ST_DONE;
		do_ins = 1'b0;
		do_del = 1'b0;
		rd_ok  = 1'b0;
		case (op)
			OP_READ: begin
				if (pos_x < cnt_x) begin
					rd_ok = 1'b1;
				end else begin
					status = ST_BADPOS;
				end
			end
			OP_INSERT: begin
				if (pos_x > cnt_x) begin
					status = ST_BADPOS;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_x >= cnt_x) begin
					status = ST_BADPOS;
				end else begin
					do_del = 1'b1;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign ctl.ins   = accept && do_ins;
	assign ctl.del   = accept && do_del;
	assign ctl.pos   = pos;
	assign ctl.value = value;

	// Chain of cells: each cell sees its lower and upper neighbor.
	logic signed [VAL_W-1:0] cell_data [CAPACITY];
	logic signed [VAL_W-1:0] cell_rd   [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left;
		logic signed [VAL_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		pida_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.left    (left),
			.right   (right),
			.data    (cell_data[i]),
			.rd_term (cell_rd[i])
		);
	end

	// Only the addressed cell drives a nonzero term; OR them together.
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// Count update and output register.
	logic [CW-1:0] count_next;

	always_comb begin
		count_next = count_q;
		if (do_ins) begin
			count_next = count_q + CW'(1);
		end else if (do_del) begin
			count_next = count_q - CW'(1);
		end
	end

	logic                    m_tvalid_q;
	logic [ST_W-1:0]         status_q;
	logic signed [VAL_W-1:0] rd_q;
	logic [CNT_W-1:0]        cnt_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status;
			rd_q      <= rd_ok ? rd_bus : '0;
			cnt_out_q <= CNT_W'(count_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({cnt_out_q, rd_q, status_q});

endmodule

FILE: rtl/pida_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_cell
// One list slot: holds a word, takes the new value or a neighbor's word on insert or delete.
// ----------------------------------------------------------------------------
module pida_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  pida_pkg::ctl_t                    ctl,
	input  logic signed [pida_pkg::VAL_W-1:0] left,
	input  logic signed [pida_pkg::VAL_W-1:0] right,
	output logic signed [pida_pkg::VAL_W-1:0] data,
	output logic signed [pida_pkg::VAL_W-1:0] rd_term
);
	import pida_pkg::*;

	logic signed [VAL_W-1:0] data_q;
	logic                    at_pos;
	logic                    above_pos;

	assign at_pos    = (32'(IDX) == 32'(ctl.pos));
	assign above_pos = (32'(IDX) >  32'(ctl.pos));

	always_ff @(posedge clk) begin
		if (ctl.ins && at_pos) begin
			data_q <= ctl.value;
		end else if (ctl.ins && above_pos) begin
			data_q <= left;
		end else if (ctl.del && (at_pos || above_pos)) begin
			data_q <= right;
		end
	end

	assign data    = data_q;
	// Drive the read bus only from the addressed slot.
	assign rd_term = at_pos ? data_q : '0;

endmodule

FILE: rtl/pida_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_checker
// Port-level checks of the positional insert/delete list, bound to the top.
// ----------------------------------------------------------------------------
module pida_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pida_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import pida_pkg::*;

	logic [ST_W-1:0]  st;
	logic [VAL_W-1:0] rdv;

	assign st  = m_tdata[ST_W-1:0];
	assign rdv = m_tdata[ST_W +: VAL_W];

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every accepted request yields a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("no result after accepted request");

	// An empty output stage never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// Failed requests return zero data.
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st != ST_DONE) |-> rdv == '0)
		else $error("nonzero read_value on failed request");

	// Nothing comes out without a request taken the cycle before or a stall.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without a request");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (.*);

FILE: test/positional_insert_delete_array_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array_test
// Self-checking bench for the positional insert/delete list.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the list and the entry count. It predicts
// status, read_value and entry_count for every request item taken on the
// s_* stream, and checks each m_* result item against the oldest prediction.
// Stimulus runs in this order:
//  - a directed opening: empty list, value extremes, every operation,
//    positions out of range, the unused operation code, and a full list;
//  - a stretch where the output is held off long enough to back up the input,
//    after a pause that lets every pending result drain;
//  - random requests in phases that alternately grow and shrink the list.
//    Most positions are in range, and the rest are anywhere in the field.
// Both sides idle in random bursts. The last phase runs with no idling.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_test;
	import pida_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	// The fourth operation code is unused, and the block treats it as a no-op.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int LIMIT_NS = 200000;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        entry_count;
	} list_result_t;

	// Mirror of the list, and the queue of results still owed by the block.
	class list_scoreboard;
		logic signed [VAL_W-1:0] words [DEPTH];
		int unsigned             held;
		list_result_t            expected_results [$];
		int                      errors;

		function new();
			held = 0;
			errors = 0;
		endfunction

		function int unsigned entries_held();
			return held;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Apply one accepted request to the mirror and queue the result it owes.
		function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] value);
			list_result_t r;
			r.status = ST_DONE;
			r.read_value = '0;
			case (op)
				OP_READ: begin
					if (pos < held)
						r.read_value = words[pos];
					else
						r.status = ST_BADPOS;
				end
				OP_INSERT: begin
					// position is checked before fullness
					if (pos > held) begin
						r.status = ST_BADPOS;
					end else if (held >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (int i = int'(held); i > int'(pos); i--)
							words[i] = words[i-1];
						words[pos] = value;
						held++;
					end
				end
				OP_DELETE: begin
					if (pos >= held) begin
						r.status = ST_BADPOS;
					end else begin
						for (int i = int'(pos); i + 1 < int'(held); i++)
							words[i] = words[i+1];
						held--;
					end
				end
				default: begin
				end
			endcase
			r.entry_count = held[CNT_W-1:0];
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			list_result_t got;
			list_result_t want;
			got.status      = data[ST_W-1:0];
			got.read_value  = data[ST_W+VAL_W-1:ST_W];
			got.entry_count = data[ST_W+VAL_W+CNT_W-1:ST_W+VAL_W];
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: status=%0d read_value=%0d entry_count=%0d",
					$time, got.status, got.read_value, got.entry_count);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status != want.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, want.status, got.status);
				errors++;
			end
			if (got.read_value != want.read_value) begin
				$display("%0t: read_value mismatch: expected %0d, actual %0d",
					$time, want.read_value, got.read_value);
				errors++;
			end
			if (got.entry_count != want.entry_count) begin
				$display("%0t: entry_count mismatch: expected %0d, actual %0d",
					$time, want.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	list_scoreboard sb = new();

	// Knobs shared by the request and result sides.
	int hold_left = 0;  // cycles the result side keeps m_tready low
	bit calm = 1'b0;    // no random stalls on either side
	bit gaps_on = 1'b1; // random idle bursts between request items
	bit grow = 1'b1;    // bias random requests toward inserts

	positional_insert_delete_array i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sample result items at the rising edge, where both sides are settled.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Result side: a long hold-off when asked for, otherwise random stall bursts.
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else if (burst > 0) begin
				m_tready <= 1'b0;
				burst--;
			end else if ($urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				burst = $urandom_range(0, 4);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one request item and hold it until the block takes it.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, value, pos, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(op, pos, value);
	endtask

	// Drop valid and put noise on the data lines while the input idles.
	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= {8'($urandom), $urandom};
		end
	endtask

	// Let every pending result item come back before going on.
	task automatic wait_drained();
		idle_input(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed requests against the current count; some positions
	// anywhere in the field so that the range checks see all bit patterns.
	task automatic random_request();
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		int unsigned      held;
		int unsigned      roll;
		held = sb.entries_held();
		roll = $urandom_range(0, 99);
		if (roll < 4)
			op = OP_UNUSED;
		else if (roll < 34)
			op = OP_READ;
		else if (roll < (grow ? 80 : 54))
			op = OP_INSERT;
		else
			op = OP_DELETE;
		if ($urandom_range(0, 99) < 15)
			pos = POS_W'($urandom_range(0, 31));
		else if (op == OP_INSERT)
			pos = POS_W'($urandom_range(0, held));
		else
			pos = (held == 0) ? '0 : POS_W'($urandom_range(0, held - 1));
		if (gaps_on && !calm && $urandom_range(0, 3) == 0)
			idle_input($urandom_range(1, 5));
		send_request(op, pos, $urandom);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty list: every position is out of range except insert at zero.
		send_request(OP_READ, 5'd0, 32'sd5);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		send_request(OP_INSERT, 5'd1, 32'sd7);
		send_request(OP_UNUSED, 5'd31, 32'sh5A5A_A5A5);
		// Value extremes at front, end and middle.
		send_request(OP_INSERT, 5'd0, 32'sh7FFF_FFFF);
		send_request(OP_INSERT, 5'd0, 32'sh8000_0000);
		send_request(OP_INSERT, 5'd2, -32'sd1);
		send_request(OP_INSERT, 5'd1, 32'sd0);
		send_request(OP_READ, 5'd0, 32'sd0);
		send_request(OP_READ, 5'd1, 32'sd0);
		send_request(OP_READ, 5'd3, 32'sd0);
		send_request(OP_READ, 5'd4, 32'sd0);
		send_request(OP_READ, 5'd31, -32'sd1);
		send_request(OP_INSERT, 5'd31, 32'sd1);
		send_request(OP_DELETE, 5'd3, 32'sd0);
		send_request(OP_DELETE, 5'd0, 32'sd0);
		send_request(OP_DELETE, 5'd4, 32'sd0);
		send_request(OP_READ, 5'd1, 32'sd0);

		// Fill the list, then poke at its full edge.
		while (sb.entries_held() < DEPTH)
			send_request(OP_INSERT, POS_W'($urandom_range(0, sb.entries_held())), $urandom);
		send_request(OP_INSERT, 5'd16, 32'sd9);
		send_request(OP_INSERT, 5'd0, 32'sd9);
		send_request(OP_INSERT, 5'd17, 32'sd9);
		send_request(OP_READ, 5'd15, 32'sd0);
		send_request(OP_READ, 5'd16, 32'sd0);
		send_request(OP_DELETE, 5'd15, 32'sd0);

		// Pause until the block is idle, then hold the output off while
		// request items keep coming, so that s_tready has to drop.
		wait_drained();
		hold_left = 40;
		repeat (20)
			random_request();

		// Random phases. The list alternately grows and shrinks.
		// The last phase has no idling on either side.
		for (int phase = 0; phase < 8; phase++) begin
			grow = (phase % 2 == 0);
			gaps_on = (phase % 3 != 2);
			if (phase == 7)
				calm = 1'b1;
			repeat (45)
				random_request();
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS positional_insert_delete_array");
		else
			$display("FAIL positional_insert_delete_array");
		$finish;
	end

	// Watchdog for a run that stalls.
	initial begin
		#(LIMIT_NS);
		$display("FAIL positional_insert_delete_array");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pida_pkg.sv
rtl/pida_cell.sv
rtl/positional_insert_delete_array.sv
rtl/pida_checker.sv
test/positional_insert_delete_array_test.sv
